// ===== hdl/psa_pkg.sv =====
// Shared types and constants for the shoelace polygon area block.
// Used by the front, queue and back modules and the top level.
`timescale 1ns / 1ps

package psa_pkg;

   localparam int CoordBits    = 24;
   localparam int TermBits     = CoordBits + 1;
   localparam int ProdBits     = 2 * TermBits;
   localparam int SumBits      = 64;
   localparam int AreaBits     = 63;
   localparam int OddBits      = 32;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   localparam int ReqDataBits  = ((2 * CoordBits + 7) / 8) * 8;
   localparam int RspDataBits  = ((2 * AreaBits + 1 + 7) / 8) * 8;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [TermBits-1:0]  term_type;
   typedef logic signed [ProdBits-1:0]  prod_type;
   typedef logic signed [SumBits-1:0]   sum_type;
   typedef logic [AreaBits-1:0]         area_type;
   typedef logic [OddBits-1:0]          odd_count_type;

   // One vertex after classification: the factors of its edge term and of
   // the closing edge back to the start vertex.
   typedef struct packed {
      term_type edge_dx;
      term_type edge_sy;
      term_type close_dx;
      term_type close_sy;
      logic     first;
      logic     last;
   } edge_item_type;

endpackage

// ===== hdl/polygon_area_shoelace.sv =====
// Shoelace polygon area over a vertex stream: one vertex accepted per cycle while the queue is not full.
// A result passes the queue and the product, term, sum, magnitude, area and output registers.
// Throughput: 1 vertex per cycle while no result waits at the output.
// The 4-entry queue takes up to 4 more vertices while a result waits at the output.
// Synchronous reset clears start/prior vertex, sum, totals and all valids.
`timescale 1ns / 1ps

module polygon_area_shoelace (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psa_pkg::ReqDataBits-1:0]   req_tdata,  // coord_x, coord_y
   input  logic                              req_tuser,  // first_vertex
   input  logic                              req_tlast,  // last_vertex
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // polygon_area, half_unit, running_total, zero pad
   output logic [psa_pkg::RspDataBits-1:0]   rsp_tdata
);
   import psa_pkg::*;

   logic          accept, queue_full, queue_empty, pop;
   edge_item_type front_item, queue_item;
   area_type      rsp_area, rsp_total;
   logic          rsp_half;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   psa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .coord_x      (coord_type'(req_tdata[CoordBits-1:0])),
      .coord_y      (coord_type'(req_tdata[2*CoordBits-1:CoordBits])),
      .first_vertex (req_tuser),
      .last_vertex  (req_tlast),
      .item         (front_item)
   );

   psa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (queue_item)
   );

   psa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (queue_item),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_area    (rsp_area),
      .rsp_half    (rsp_half),
      .rsp_total   (rsp_total)
   );

   assign rsp_tdata = RspDataBits'({rsp_total, rsp_half, rsp_area});

endmodule

// ===== hdl/psa_front.sv =====
// Front part: accepts vertices, tracks start and prior vertex, forms the
// edge and closing-edge factors. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  psa_pkg::coord_type     coord_x,
   input  psa_pkg::coord_type     coord_y,
   input  logic                   first_vertex,
   input  logic                   last_vertex,
   output psa_pkg::edge_item_type item
);
   import psa_pkg::*;

   coord_type start_x_ff, start_y_ff, prior_x_ff, prior_y_ff;
   coord_type start_x_sel, start_y_sel;

   // A first vertex is its own start vertex.
   assign start_x_sel = first_vertex ? coord_x : start_x_ff;
   assign start_y_sel = first_vertex ? coord_y : start_y_ff;

   always_comb begin
      item.edge_dx  = term_type'(prior_x_ff) - term_type'(coord_x);
      item.edge_sy  = term_type'(prior_y_ff) + term_type'(coord_y);
      item.close_dx = term_type'(coord_x) - term_type'(start_x_sel);
      item.close_sy = term_type'(coord_y) + term_type'(start_y_sel);
      item.first    = first_vertex;
      item.last     = last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         prior_x_ff <= '0;
         prior_y_ff <= '0;
      end else if (accept) begin
         start_x_ff <= start_x_sel;
         start_y_ff <= start_y_sel;
         prior_x_ff <= coord_x;
         prior_y_ff <= coord_y;
      end
   end

endmodule

// ===== hdl/psa_queue.sv =====
// Short queue between front and back of the shoelace area block.
// Depends on psa_pkg for the item type and depth.
`timescale 1ns / 1ps

module psa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  psa_pkg::edge_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output psa_pkg::edge_item_type pop_item
);
   import psa_pkg::*;

   edge_item_type               slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntBits-1:0]     count_ff;

   assign full     = (count_ff == QueueCntBits'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/psa_back.sv =====
// Back part: multiplies, accumulates the doubled area, takes magnitude,
// keeps saturating totals and holds the result register. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  psa_pkg::edge_item_type queue_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output psa_pkg::area_type      rsp_area,
   output logic                   rsp_half,
   output psa_pkg::area_type      rsp_total
);
   import psa_pkg::*;

   logic          adv;
   // stage 1: products
   logic          v1_ff, first1_ff, last1_ff;
   prod_type      eprod_ff, cprod_ff;
   // stage 2: term to add
   logic          v2_ff, first2_ff, last2_ff;
   sum_type       term_ff;
   // stage 3: running doubled area
   logic          l3_ff;
   sum_type       sum_ff;
   // stage 4: magnitude
   logic          l4_ff;
   logic [SumBits-1:0] mag_ff;
   // stage 5: totals
   logic          l5_ff;
   area_type      area_ff, floored_total_ff;
   logic          half_ff;
   odd_count_type odd_count_ff;
   // output register
   logic          rsp_valid_ff, rsp_half_ff;
   area_type      rsp_area_ff, rsp_total_ff;

   sum_type            term_in, sum_in;
   logic [SumBits-1:0] mag_in, floored_sum, total_sum;
   area_type           area_in, floored_total_in, rsp_total_in;
   odd_count_type      odd_count_in;

   // Hold the whole back part while a result waits to be taken.
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !queue_empty;

   always_comb begin
      term_in = (first1_ff ? sum_type'(0) : sum_type'(eprod_ff))
              + (last1_ff ? sum_type'(cprod_ff) : sum_type'(0));
      sum_in  = (first2_ff ? sum_type'(0) : sum_ff) + term_ff;
      mag_in  = sum_ff[SumBits-1] ? (~sum_ff + 1'b1) : sum_ff;
      area_in = mag_ff[SumBits-1:1];

      floored_sum = {1'b0, floored_total_ff} + {1'b0, area_in};
      floored_total_in = floored_sum[SumBits-1] ? '1 : floored_sum[AreaBits-1:0];
      odd_count_in = (mag_ff[0] && odd_count_ff != '1) ? odd_count_ff + 1'b1
                                                         : odd_count_ff;

      total_sum = {1'b0, floored_total_ff} + SumBits'(odd_count_ff[OddBits-1:1]);
      rsp_total_in = total_sum[SumBits-1] ? '1 : total_sum[AreaBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eprod_ff  <= queue_item.edge_dx * queue_item.edge_sy;
         cprod_ff  <= queue_item.close_dx * queue_item.close_sy;
         first1_ff <= queue_item.first;
         last1_ff  <= queue_item.last;
         term_ff   <= term_in;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         if (l3_ff) begin
            mag_ff <= mag_in;
         end
         if (l4_ff) begin
            area_ff <= area_in;
            half_ff <= mag_ff[0];
         end
         if (l5_ff) begin
            rsp_area_ff  <= area_ff;
            rsp_half_ff  <= half_ff;
            rsp_total_ff <= rsp_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         l3_ff            <= 1'b0;
         l4_ff            <= 1'b0;
         l5_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sum_ff           <= '0;
         floored_total_ff <= '0;
         odd_count_ff     <= '0;
      end else if (adv) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         l3_ff        <= v2_ff && last2_ff;
         l4_ff        <= l3_ff;
         l5_ff        <= l4_ff;
         rsp_valid_ff <= l5_ff;
         if (v2_ff) begin
            sum_ff <= sum_in;
         end
         if (l4_ff) begin
            floored_total_ff <= floored_total_in;
            odd_count_ff     <= odd_count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_area  = rsp_area_ff;
   assign rsp_half  = rsp_half_ff;
   assign rsp_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_floored_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> floored_total_ff >= $past(floored_total_ff))
      else $error("floored total decreased");

   a_odd_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> odd_count_ff >= $past(odd_count_ff))
      else $error("odd polygon count decreased");

   a_stall_holds_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(sum_ff) && $stable(l5_ff))
      else $error("accumulator moved while result stalled");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("queue popped while result stalled");
`endif

endmodule
